FILE: design/lph_pkg.sv
// Shared types and constants for the linear probing hash lookup block.
// Depends on nothing; every other design file but lph_if refers to it by scoped names.
package lph_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CAP_W       = IDX_W + 1;
	localparam int KEY_WIDTH   = 32;
	localparam int HASH_W      = 64;
	localparam int POS_W       = 11;
	localparam int DIV_BITS    = 8;
	localparam int DIV_STEPS   = HASH_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [0:0] ACT_WRITE = 1'b0;
	localparam logic [0:0] ACT_FIND  = 1'b1;

	localparam logic [1:0] ST_UNUSED  = 2'd0;
	localparam logic [1:0] ST_DELETED = 2'd1;

	localparam logic [1:0] OUT_FOUND     = 2'd0;
	localparam logic [1:0] OUT_UNUSED    = 2'd1;
	localparam logic [1:0] OUT_EXHAUSTED = 2'd2;
	localparam logic [1:0] OUT_WRITE_ACK = 2'd3;

	localparam logic [POS_W-1:0] POS_MISSING = '1;

	// Register index of the capacity register.
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(TABLE_DEPTH);

	typedef struct packed {
		logic                 is_find;
		logic [IDX_W-1:0]     pos;
		logic [1:0]           status;
		logic [KEY_WIDTH-1:0] key;
		logic                 report;
	} lph_entry_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [KEY_WIDTH-1:0] key;
	} slot_word_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} back_state_t;

endpackage

FILE: design/lph_if.sv
// Valid/ready channel interfaces for the item input and the result output.
// Does not depend on lph_pkg; its field widths are written out to match the package.
interface lph_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [9:0]  slot_index;
	logic [1:0]  slot_status_in;
	logic [31:0] slot_key_in;
	logic [31:0] search_key;
	logic [63:0] search_hash;
	logic        report_offset;

	modport source (output valid, action, slot_index, slot_status_in, slot_key_in,
		search_key, search_hash, report_offset, input ready);
	modport sink (input valid, action, slot_index, slot_status_in, slot_key_in,
		search_key, search_hash, report_offset, output ready);
endinterface

interface lph_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         outcome;
	logic signed [10:0] result_position;

	modport source (output valid, outcome, result_position, input ready);
	modport sink (input valid, outcome, result_position, output ready);
endinterface

FILE: design/linear_probe_hash_lookup.sv
// Top level of the linear probing hash lookup block: configuration register,
// front end, entry queue and back end. Depends on lph_pkg, lph_if and submodules.
//
// Use: items enter on in_ch (valid/ready). A write beat (action 0) stores a
// status and key into one slot; a find beat (action 1) looks up search_key
// starting at search_hash modulo the capacity and walking forward with wrap.
// Every item yields exactly one result beat on out_ch, in input order: found,
// unused slot reached, table exhausted, or write acknowledged.
// The capacity register sits at APB byte address 0. The user must write it
// only while no item is in flight; the block itself does not enforce this.
// Values of zero act as one, values above the table depth as the table depth.
// A write is registered in the front end, passes through the queue, and is
// applied to the slot memory by the back end, which loads its acknowledgment
// into the output register. A find is held in the front end while it reduces
// the 64-bit hash eight bits per cycle, then the back end probes slot after
// slot, reading the slot memory through one registered read port. The front
// end takes no new item until it has pushed the last one into the queue, and
// the back end finishes one entry before it pops the next.
// After reset the back end clears the status of all 1024 slots, one per
// cycle; in_ch.ready stays low until that clearing pass is done.
// When the receiver stalls, the result is held in the output register and
// up to four classified entries wait in the queue, so the front keeps
// accepting items until that queue fills.
module linear_probe_hash_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	lph_in_if.sink                            in_ch,
	lph_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lph_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [lph_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lph_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	logic [lph_pkg::CAP_W-1:0] cap_q;
	logic [lph_pkg::CAP_W-1:0] eff_cap;
	logic                      cap_sel;
	logic                      clearing;
	logic                      push;
	logic                      pop;
	logic                      q_full;
	logic                      q_empty;
	lph_pkg::lph_entry_t       push_data;
	lph_pkg::lph_entry_t       head;

	// Register index is the word address; only the capacity register exists.
	assign cap_sel = (paddr[lph_pkg::APB_ADDR_W-1] == lph_pkg::REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? lph_pkg::APB_DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lph_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			cap_q <= pwdata[lph_pkg::CAP_W-1:0];
		end
	end

	// Clamp the programmed capacity to the range the table supports.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lph_pkg::CAP_W'(1);
		end else if (cap_q > lph_pkg::CAP_W'(lph_pkg::TABLE_DEPTH)) begin
			eff_cap = lph_pkg::CAP_W'(lph_pkg::TABLE_DEPTH);
		end else begin
			eff_cap = cap_q;
		end
	end

	lph_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cap       (eff_cap),
		.clearing  (clearing),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	lph_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	lph_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap      (eff_cap),
		.clearing (clearing),
		.pop      (pop),
		.head     (head),
		.q_empty  (q_empty),
		.out_ch   (out_ch)
	);

endmodule

FILE: design/lph_queue.sv
// Small FIFO of classified entries between the front and the back.
// Depends on lph_pkg for the entry type and depth.
module lph_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lph_pkg::lph_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output lph_pkg::lph_entry_t head,
	output logic                empty
);

	lph_pkg::lph_entry_t            entry_q [lph_pkg::QUEUE_DEPTH];
	logic [lph_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lph_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lph_pkg::QCNT_W-1:0]     count_q;

	assign full  = (count_q == lph_pkg::QCNT_W'(lph_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/lph_front.sv
// Front end: accepts items, reduces the hash of a find modulo the capacity
// eight bits per cycle, and pushes classified entries. Depends on lph_pkg, lph_if.
module lph_front (
	input  logic                       clk,
	input  logic                       arst_n,
	lph_in_if.sink                     in_ch,
	input  logic [lph_pkg::CAP_W-1:0]  cap,
	input  logic                       clearing,
	output logic                       push,
	output lph_pkg::lph_entry_t        push_data,
	input  logic                       q_full
);

	lph_pkg::front_state_t              state_q;
	lph_pkg::front_state_t              state_nx;
	lph_pkg::lph_entry_t                ent_q;
	logic [lph_pkg::HASH_W-1:0]         hash_q;
	logic [lph_pkg::CAP_W-1:0]          rem_q;
	logic [lph_pkg::CAP_W-1:0]          rem_nx;
	logic [lph_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                               accept;

	// Restoring remainder, one hash bit per inner step.
	always_comb begin
		logic [lph_pkg::CAP_W:0] t;
		rem_nx = rem_q;
		for (int i = 0; i < lph_pkg::DIV_BITS; i++) begin
			t = {rem_nx, hash_q[lph_pkg::HASH_W-1-i]};
			if (t >= {1'b0, cap}) begin
				t = t - {1'b0, cap};
			end
			rem_nx = t[lph_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lph_pkg::F_IDLE: begin
				if (accept) begin
					state_nx = (in_ch.action == lph_pkg::ACT_FIND) ? lph_pkg::F_DIV
						: lph_pkg::F_PUSH;
				end
			end
			lph_pkg::F_DIV: begin
				if (cnt_q == lph_pkg::DIV_CNT_W'(lph_pkg::DIV_STEPS - 1)) begin
					state_nx = lph_pkg::F_PUSH;
				end
			end
			lph_pkg::F_PUSH: begin
				if (!q_full) begin
					state_nx = lph_pkg::F_IDLE;
				end
			end
			default: state_nx = lph_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		push        = 1'b0;
		case (state_q)
			lph_pkg::F_IDLE: in_ch.ready = !clearing;
			lph_pkg::F_PUSH: push = !q_full;
			default: begin
			end
		endcase
	end

	assign accept    = in_ch.valid && in_ch.ready;
	assign push_data = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lph_pkg::F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == lph_pkg::F_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.is_find <= (in_ch.action == lph_pkg::ACT_FIND);
			ent_q.pos     <= in_ch.slot_index;
			ent_q.status  <= in_ch.slot_status_in;
			ent_q.key     <= (in_ch.action == lph_pkg::ACT_FIND)
				? in_ch.search_key[lph_pkg::KEY_WIDTH-1:0]
				: in_ch.slot_key_in[lph_pkg::KEY_WIDTH-1:0];
			ent_q.report  <= in_ch.report_offset;
			hash_q        <= in_ch.search_hash;
			rem_q         <= '0;
		end else if (state_q == lph_pkg::F_DIV) begin
			hash_q <= hash_q << lph_pkg::DIV_BITS;
			rem_q  <= rem_nx;
			if (cnt_q == lph_pkg::DIV_CNT_W'(lph_pkg::DIV_STEPS - 1)) begin
				ent_q.pos <= rem_nx[lph_pkg::IDX_W-1:0];
			end
		end
	end

endmodule

FILE: design/lph_back.sv
// Back end: owns the slot memory, runs the reset clearing pass, applies
// writes and walks probes one slot per cycle. Depends on lph_pkg, lph_if.
module lph_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lph_pkg::CAP_W-1:0]  cap,
	output logic                       clearing,
	output logic                       pop,
	input  lph_pkg::lph_entry_t        head,
	input  logic                       q_empty,
	lph_out_if.source                  out_ch
);

	lph_pkg::back_state_t              state_q;
	lph_pkg::back_state_t              state_nx;
	lph_pkg::slot_word_t               slot_mem_q [lph_pkg::TABLE_DEPTH];
	lph_pkg::slot_word_t               rd_data_q;
	lph_pkg::slot_word_t               wdata;
	logic [lph_pkg::IDX_W-1:0]         waddr;
	logic [lph_pkg::IDX_W-1:0]         raddr;
	logic                              we;
	logic [lph_pkg::IDX_W-1:0]         clr_idx_q;
	logic [lph_pkg::IDX_W-1:0]         pos_q;
	logic [lph_pkg::CAP_W-1:0]         probes_q;
	logic [lph_pkg::KEY_WIDTH-1:0]     key_q;
	logic                              report_q;
	logic                              out_valid_q;
	logic [1:0]                        outcome_q;
	logic [lph_pkg::POS_W-1:0]         position_q;
	logic                              can_out;
	logic                              out_load;
	logic [1:0]                        out_outcome;
	logic [lph_pkg::POS_W-1:0]         out_position;
	logic                              hit_unused;
	logic                              hit_key;
	logic                              exhaust;
	logic                              probe_done;
	logic [lph_pkg::CAP_W-1:0]         probes_nx;
	logic [lph_pkg::CAP_W-1:0]         pos_inc;
	logic [lph_pkg::IDX_W-1:0]         pos_wrap;
	logic [1:0]                        probe_outcome;
	logic [lph_pkg::IDX_W-1:0]         probe_pos;

	assign can_out = !out_valid_q || out_ch.ready;

	// Evaluation of the slot read in the previous cycle.
	assign hit_unused = (rd_data_q.status == lph_pkg::ST_UNUSED);
	assign hit_key    = (rd_data_q.status != lph_pkg::ST_DELETED) && (rd_data_q.key == key_q);
	assign probes_nx  = probes_q + 1'b1;
	assign pos_inc    = {1'b0, pos_q} + 1'b1;
	assign pos_wrap   = (pos_inc == cap) ? '0 : pos_inc[lph_pkg::IDX_W-1:0];
	assign exhaust    = (probes_nx > cap);
	assign probe_done = hit_unused || hit_key || exhaust;

	always_comb begin
		if (hit_unused) begin
			probe_outcome = lph_pkg::OUT_UNUSED;
			probe_pos     = pos_q;
		end else if (hit_key) begin
			probe_outcome = lph_pkg::OUT_FOUND;
			probe_pos     = pos_q;
		end else begin
			probe_outcome = lph_pkg::OUT_EXHAUSTED;
			probe_pos     = pos_wrap;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lph_pkg::B_CLEAR: begin
				if (clr_idx_q == lph_pkg::IDX_W'(lph_pkg::TABLE_DEPTH - 1)) begin
					state_nx = lph_pkg::B_IDLE;
				end
			end
			lph_pkg::B_IDLE: begin
				if (!q_empty && head.is_find) begin
					state_nx = lph_pkg::B_PROBE;
				end
			end
			lph_pkg::B_PROBE: begin
				if (probe_done && can_out) begin
					state_nx = lph_pkg::B_IDLE;
				end
			end
			default: state_nx = lph_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		clearing     = 1'b0;
		pop          = 1'b0;
		we           = 1'b0;
		waddr        = head.pos;
		wdata.status = head.status;
		wdata.key    = head.key;
		raddr        = head.pos;
		out_load     = 1'b0;
		out_outcome  = probe_outcome;
		out_position = lph_pkg::POS_W'(probe_pos);
		case (state_q)
			lph_pkg::B_CLEAR: begin
				clearing     = 1'b1;
				we           = 1'b1;
				waddr        = clr_idx_q;
				wdata.status = lph_pkg::ST_UNUSED;
				wdata.key    = '0;
			end
			lph_pkg::B_IDLE: begin
				if (!q_empty) begin
					if (head.is_find) begin
						pop = 1'b1;
					end else if (can_out) begin
						pop          = 1'b1;
						we           = 1'b1;
						out_load     = 1'b1;
						out_outcome  = lph_pkg::OUT_WRITE_ACK;
						out_position = lph_pkg::POS_W'(head.pos);
					end
				end
			end
			lph_pkg::B_PROBE: begin
				// Keep reading ahead so that the next slot arrives next cycle.
				raddr = probe_done ? pos_q : pos_wrap;
				if (probe_done && can_out) begin
					out_load = 1'b1;
					if (probe_outcome != lph_pkg::OUT_FOUND && !report_q) begin
						out_position = lph_pkg::POS_MISSING;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem_q[waddr] <= wdata;
		end
		rd_data_q <= slot_mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lph_pkg::B_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == lph_pkg::B_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lph_pkg::B_IDLE && pop && head.is_find) begin
			pos_q    <= head.pos;
			probes_q <= '0;
			key_q    <= head.key;
			report_q <= head.report;
		end else if (state_q == lph_pkg::B_PROBE && !probe_done) begin
			pos_q    <= pos_wrap;
			probes_q <= probes_nx;
		end
		if (out_load) begin
			outcome_q  <= out_outcome;
			position_q <= out_position;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.outcome         = outcome_q;
	assign out_ch.result_position = position_q;

endmodule

FILE: design/lph_checker.sv
// Port-level checks for linear_probe_hash_lookup, attached with bind.
// Depends on lph_pkg for outcome codes.
module lph_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  outcome,
	input logic [10:0] result_position
);

	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A result is only delivered for an item that was accepted earlier.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 4'd0)
		else $error("result delivered with no item outstanding");

	// A stalled result keeps its payload.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(result_position))
		else $error("stalled result changed");

	// Found results and write acknowledgments carry a real slot position.
	a_position_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == lph_pkg::OUT_FOUND || outcome == lph_pkg::OUT_WRITE_ACK)
		|-> !result_position[10])
		else $error("found or write result carries an out-of-table position");

endmodule

bind linear_probe_hash_lookup lph_checker u_lph_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.outcome         (out_ch.outcome),
	.result_position (out_ch.result_position)
);
